### hw/rtl/mvb_pkg.sv
// Shared types, constants and the X.25 CRC step for the MAVLink v1 frame builder.
package mvb_pkg;

  // Frame constants
  localparam logic [7:0]  MavStx     = 8'hFE;
  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [7:0]  SeqByte    = 8'h00;
  localparam int unsigned HdrBytes   = 6;
  localparam int unsigned ResMax     = 8;
  localparam int unsigned ResIdxW    = $clog2(ResMax);
  localparam int unsigned ResCntW    = $clog2(ResMax + 1);
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 8;

  // Request kind carried in in_tuser
  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_PAYLOAD = 1'b1
  } mode_t;

  // Configuration register index
  typedef enum logic [0:0] {
    CFG_SYSTEM_ID    = 1'b0,
    CFG_COMPONENT_ID = 1'b1
  } cfg_idx_t;

  typedef logic [7:0] byte_t;
  typedef logic [ResCntW-1:0] res_cnt_t;

  // Fold one byte into an X.25 CRC-16 accumulator
  function automatic logic [15:0] crc_fold(logic [15:0] crc, byte_t b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

### hw/rtl/mavlink_v1_frame_builder.sv
// MAVLink v1 frame builder: turns start and payload requests into a framed byte stream.
//
// Input channel (in_*): one request per handshake. in_tuser selects the kind:
//   start (0) opens a frame with message id, payload length and CRC extra byte;
//   payload (1) supplies the next payload byte of the open frame.
// Output channel (out_*): one frame byte per handshake; out_tlast marks the
//   final byte caused by a request, out_tuser flags a payload byte that came
//   with no frame open (that byte is 0x00).
// Configuration port: cfg_we writes system id (index 0) or component id (1).
// A start request gives 6 bytes (8 for a zero-length payload, CRC appended);
// a payload request gives 1 byte, or 3 with the CRC after the last one.
// With the result buffer free, an accepted request passes the input stage
//   register and then the result buffer register before its first byte is valid.
// Throughput: one output byte per cycle while out_tready is high; a request
//   holds the result buffer until its last byte is taken, so single-byte payload requests go at one per cycle.
//   The rate is set by the single-byte output port draining the result buffer.
// Reset clears the input stage, the result buffer and the frame state, sets
//   the CRC to 0xFFFF, system id to 1 and component id to 255.
// When the receiver stalls, the current byte holds; the input stage keeps one
//   request and in_tready drops once it can no longer advance.
module mavlink_v1_frame_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // message_id[7:0], message_length[15:8], extra_byte[23:16], payload_byte[31:24]
  input  logic [mvb_pkg::InDataW-1:0]   in_tdata,
  // mode[0]
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_byte[7:0]
  output logic [mvb_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast,
  // frame_error[0]
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_we,
  input  mvb_pkg::cfg_idx_t             cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import mvb_pkg::*;

  // Input stage
  logic     s1_valid_r;
  mode_t    s1_mode_r;
  byte_t    s1_mid_r, s1_len_r, s1_extra_r, s1_pay_r;

  // Frame state
  logic [15:0] crc_r, crc_nxt;
  byte_t       brem_r, brem_nxt;
  logic        open_r, open_nxt;
  byte_t       extra_r, extra_nxt;
  byte_t       sys_id_r, comp_id_r;

  // Result buffer: shifts down one byte per output handshake
  byte_t       obuf_r [ResMax];
  byte_t       obuf_nxt [ResMax];
  res_cnt_t    rem_r, rem_nxt;
  logic        err_r, err_nxt;

  // Values computed for the request in the input stage
  byte_t       res_byte [ResMax];
  res_cnt_t    res_cnt;
  logic        res_err;
  logic [15:0] hdr_crc, start_fin_crc, pay_crc, pay_fin_crc;
  byte_t       brem_dec;

  logic out_take, buf_free, s1_load, in_take;

  // Handshake control
  assign out_tvalid = (rem_r != '0);
  assign out_take   = out_tvalid && out_tready;
  assign buf_free   = (rem_r == '0) || ((rem_r == res_cnt_t'(1)) && out_tready);
  assign s1_load    = s1_valid_r && buf_free;
  assign in_tready  = !s1_valid_r || buf_free;
  assign in_take    = in_tvalid && in_tready;

  assign out_tdata  = obuf_r[0];
  assign out_tlast  = (rem_r == res_cnt_t'(1));
  assign out_tuser  = err_r;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= mode_t'(in_tuser);
      s1_mid_r   <= in_tdata[7:0];
      s1_len_r   <= in_tdata[15:8];
      s1_extra_r <= in_tdata[23:16];
      s1_pay_r   <= in_tdata[31:24];
    end
  end

  // CRC paths: header seed chain, payload step, and the closing extra-byte fold
  always_comb begin
    hdr_crc       = crc_fold(CrcSeed, s1_len_r);
    hdr_crc       = crc_fold(hdr_crc, SeqByte);
    hdr_crc       = crc_fold(hdr_crc, sys_id_r);
    hdr_crc       = crc_fold(hdr_crc, comp_id_r);
    hdr_crc       = crc_fold(hdr_crc, s1_mid_r);
    start_fin_crc = crc_fold(hdr_crc, s1_extra_r);
    pay_crc       = crc_fold(crc_r, s1_pay_r);
    pay_fin_crc   = crc_fold(pay_crc, extra_r);
    brem_dec      = brem_r - 8'd1;
  end

  // Work out the result bytes and the next frame state
  always_comb begin
    for (int i = 0; i < ResMax; i++) begin
      res_byte[i] = 8'h00;
    end
    res_cnt   = '0;
    res_err   = 1'b0;
    crc_nxt   = crc_r;
    brem_nxt  = brem_r;
    open_nxt  = open_r;
    extra_nxt = extra_r;
    unique case (s1_mode_r)
      MODE_START: begin
        res_byte[0] = MavStx;
        res_byte[1] = s1_len_r;
        res_byte[2] = SeqByte;
        res_byte[3] = sys_id_r;
        res_byte[4] = comp_id_r;
        res_byte[5] = s1_mid_r;
        extra_nxt   = s1_extra_r;
        if (s1_len_r == 8'd0) begin
          res_byte[6] = start_fin_crc[7:0];
          res_byte[7] = start_fin_crc[15:8];
          res_cnt     = res_cnt_t'(ResMax);
          crc_nxt     = start_fin_crc;
          brem_nxt    = 8'd0;
          open_nxt    = 1'b0;
        end else begin
          res_cnt  = res_cnt_t'(HdrBytes);
          crc_nxt  = hdr_crc;
          brem_nxt = s1_len_r;
          open_nxt = 1'b1;
        end
      end
      MODE_PAYLOAD: begin
        if (!open_r) begin
          // Stray payload byte: flag it, leave the state alone
          res_cnt = res_cnt_t'(1);
          res_err = 1'b1;
        end else if (brem_dec == 8'd0) begin
          res_byte[0] = s1_pay_r;
          res_byte[1] = pay_fin_crc[7:0];
          res_byte[2] = pay_fin_crc[15:8];
          res_cnt     = res_cnt_t'(3);
          crc_nxt     = pay_fin_crc;
          brem_nxt    = 8'd0;
          open_nxt    = 1'b0;
        end else begin
          res_byte[0] = s1_pay_r;
          res_cnt     = res_cnt_t'(1);
          crc_nxt     = pay_crc;
          brem_nxt    = brem_dec;
        end
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

  // Frame state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CrcSeed;
      brem_r    <= 8'd0;
      open_r    <= 1'b0;
      extra_r   <= 8'd0;
      sys_id_r  <= 8'd1;
      comp_id_r <= 8'd255;
    end else begin
      if (s1_load) begin
        crc_r   <= crc_nxt;
        brem_r  <= brem_nxt;
        open_r  <= open_nxt;
        extra_r <= extra_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYSTEM_ID:    sys_id_r  <= cfg_wdata;
          CFG_COMPONENT_ID: comp_id_r <= cfg_wdata;
          default:          sys_id_r  <= sys_id_r;
        endcase
      end
    end
  end

  // Load or advance the result buffer
  always_comb begin
    for (int i = 0; i < ResMax; i++) begin
      obuf_nxt[i] = obuf_r[i];
    end
    rem_nxt = rem_r;
    err_nxt = err_r;
    if (s1_load) begin
      for (int i = 0; i < ResMax; i++) begin
        obuf_nxt[i] = res_byte[i];
      end
      rem_nxt = res_cnt;
      err_nxt = res_err;
    end else if (out_take) begin
      for (int i = 0; i < ResMax - 1; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
      rem_nxt = rem_r - res_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      err_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ResMax; i++) begin
      obuf_r[i] <= obuf_nxt[i];
    end
  end

endmodule
